// File: rtl/bfba_pkg.sv
`default_nettype none

package bfba_pkg;

    // field widths of the item channels
    localparam int OP_W      = 1;
    localparam int SLOT_W    = 4;
    localparam int SIZE_IN_W = 16;
    localparam int TOTAL_W   = 20;

    // saturation ceiling of the free total
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

    // item opcodes
    localparam logic [OP_W-1:0] OP_WRITE   = 1'b0;
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

    // register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CFG_W   = 5;

    // word index of each register (paddr bit 2)
    localparam logic REG_BLOCKS_IN_USE = 1'b0;

    localparam logic [CFG_W-1:0] BLOCKS_IN_USE_RESET = 5'd16;

endpackage

`default_nettype wire

// File: rtl/bfba_req_if.sv
`default_nettype none

// request channel: block writes and allocation requests
interface bfba_req_if;
    logic                               valid;
    logic                               ready;
    logic [bfba_pkg::OP_W-1:0]          op;
    logic [bfba_pkg::SLOT_W-1:0]        block_slot;
    logic [bfba_pkg::SIZE_IN_W-1:0]     size_value;

    modport source (output valid, op, block_slot, size_value, input ready);
    modport sink   (input valid, op, block_slot, size_value, output ready);
endinterface

`default_nettype wire

// File: rtl/bfba_res_if.sv
`default_nettype none

// result channel: one transfer per allocation request
interface bfba_res_if;
    logic                               valid;
    logic                               ready;
    logic                               granted;
    logic [bfba_pkg::SLOT_W-1:0]        chosen_block;
    logic [bfba_pkg::TOTAL_W-1:0]       free_total;

    modport source (output valid, granted, chosen_block, free_total, input ready);
    modport sink   (input valid, granted, chosen_block, free_total, output ready);
endinterface

`default_nettype wire

// File: rtl/bfba_apb_regs.sv
`default_nettype none

module bfba_apb_regs #(
    parameter int MAX_BLOCKS = 16,
    parameter int CNT_W      = 5
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bfba_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bfba_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bfba_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    output logic      [CNT_W-1:0]               n_active
);

    localparam int CMP_W = (CNT_W > bfba_pkg::CFG_W) ? CNT_W : bfba_pkg::CFG_W;

    logic [bfba_pkg::CFG_W-1:0] blocks_in_use_reg;
    logic [bfba_pkg::CFG_W-1:0] blocks_in_use_next;
    logic                       wr_en;
    logic [CMP_W-1:0]           cfg_ext;
    logic [CMP_W-1:0]           max_ext;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == bfba_pkg::REG_BLOCKS_IN_USE);

    // register write
    always_comb
    begin
        blocks_in_use_next = blocks_in_use_reg;
        if (wr_en)
        begin
            blocks_in_use_next = pwdata[bfba_pkg::CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_in_use_reg <= bfba_pkg::BLOCKS_IN_USE_RESET;
        end
        else
        begin
            blocks_in_use_reg <= blocks_in_use_next;
        end
    end

    // read back
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == bfba_pkg::REG_BLOCKS_IN_USE)
        begin
            prdata = bfba_pkg::PDATA_W'(blocks_in_use_reg);
        end
    end

    // entries taking part, clipped to the table depth
    assign cfg_ext  = CMP_W'(blocks_in_use_reg);
    assign max_ext  = CMP_W'(MAX_BLOCKS);
    assign n_active = (cfg_ext > max_ext) ? max_ext[CNT_W-1:0] : cfg_ext[CNT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/best_fit_block_allocator.sv
// Best-fit block allocator. A write transfer (op 0) loads the free size of one
// table entry and gives no result; a slot beyond the table is ignored. A
// request transfer (op 1) scans the first blocks_in_use entries (at most the
// table depth), picks the smallest free size that still covers the request
// (lowest index on a tie), subtracts the request from it and returns granted,
// the chosen index and the total free space of the entries in use. A failed
// request halts the allocator: later requests are refused until the next block
// write. The free sizes sit in one memory with a registered read port that is
// scanned one entry per cycle; each entry is compared once its registered read
// returns, and an update state then writes the chosen entry and registers the
// result; no new transfer is taken before then. While an earlier result still
// waits on the result channel, the table update and the new result wait with
// it for as long as it stays untaken. Entries read before they were ever
// written return unspecified sizes; there is no clearing pass after reset.
// blocks_in_use sits at byte address 0 of the register port.
`default_nettype none

module best_fit_block_allocator #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bfba_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [bfba_pkg::PDATA_W-1:0]   pwdata,
    output logic      [bfba_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    bfba_req_if.sink                            req,
    bfba_res_if.source                          res
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int SUM_W = SIZE_BITS + IDX_W;
    localparam int CMP_W = (SUM_W > bfba_pkg::TOTAL_W) ? SUM_W : bfba_pkg::TOTAL_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    // control
    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic                           found_reg, found_next;
    logic                           halted_reg, halted_next;
    logic                           out_valid_reg, out_valid_next;

    // datapath
    logic [IDX_W-1:0]               pend_idx_reg, pend_idx_next;
    logic [SUM_W-1:0]               sum_reg, sum_next;
    logic [IDX_W-1:0]               best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0]           best_size_reg, best_size_next;
    logic [SIZE_BITS-1:0]           size_reg, size_next;
    logic [CNT_W-1:0]               n_reg, n_next;
    logic                           granted_reg, granted_next;
    logic [bfba_pkg::SLOT_W-1:0]    chosen_reg, chosen_next;
    logic [bfba_pkg::TOTAL_W-1:0]   total_reg, total_next;

    // memory port
    logic [SIZE_BITS-1:0]           block_free [MAX_BLOCKS];
    logic [SIZE_BITS-1:0]           rd_data_reg;
    logic [IDX_W-1:0]               rd_addr;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [SIZE_BITS-1:0]           mem_wdata;

    logic [CNT_W-1:0]               n_active;
    logic                           req_fire;
    logic                           slot_ok;
    logic [SIZE_BITS-1:0]           size_in;
    logic                           scan_issue;
    logic                           out_free;
    logic [SUM_W-1:0]               total_diff;
    logic [CMP_W-1:0]               total_ext;

    bfba_apb_regs #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .CNT_W      (CNT_W)
    ) u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .n_active (n_active)
    );

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign slot_ok    = (32'(req.block_slot) < MAX_BLOCKS);
    assign size_in    = SIZE_BITS'(req.size_value);
    assign scan_issue = (idx_reg < n_reg);
    assign rd_addr    = idx_reg[IDX_W-1:0];
    assign out_free   = !out_valid_reg || res.ready;

    // free total after the step, saturated in the update state
    assign total_diff = sum_reg - (found_reg ? SUM_W'(size_reg) : '0);
    assign total_ext  = CMP_W'(total_diff);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        halted_next    = halted_reg;
        pend_idx_next  = pend_idx_reg;
        sum_next       = sum_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        size_next      = size_reg;
        n_next         = n_reg;
        mem_we         = 1'b0;
        mem_waddr      = best_idx_reg;
        mem_wdata      = best_size_reg - size_reg;
        out_valid_next = out_valid_reg && !res.ready;
        granted_next   = granted_reg;
        chosen_next    = chosen_reg;
        total_next     = total_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.op == bfba_pkg::OP_REQUEST)
                    begin
                        idx_next       = '0;
                        found_next     = 1'b0;
                        sum_next       = '0;
                        best_idx_next  = '0;
                        best_size_next = '0;
                        size_next      = size_in;
                        n_next         = n_active;
                        state_next     = ST_SCAN;
                    end
                    else if (slot_ok)
                    begin
                        // block write restarts a halted run
                        mem_we      = 1'b1;
                        mem_waddr   = IDX_W'(req.block_slot);
                        mem_wdata   = size_in;
                        halted_next = 1'b0;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue one read per cycle
                if (scan_issue)
                begin
                    idx_next      = CNT_W'(idx_reg + 1'b1);
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IDX_W-1:0];
                end
                // compare the entry read last cycle
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                    if (!halted_reg && (rd_data_reg >= size_reg)
                        && (!found_reg || (rd_data_reg < best_size_reg)))
                    begin
                        found_next     = 1'b1;
                        best_idx_next  = pend_idx_reg;
                        best_size_next = rd_data_reg;
                    end
                end
                if (!scan_issue && !pend_reg)
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (out_free)
                begin
                    if (found_reg)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        halted_next = 1'b1;
                    end
                    out_valid_next = 1'b1;
                    granted_next   = found_reg;
                    chosen_next    = found_reg ? bfba_pkg::SLOT_W'(best_idx_reg) : '0;
                    total_next     = (total_ext > CMP_W'(bfba_pkg::TOTAL_MAX))
                                     ? bfba_pkg::TOTAL_MAX
                                     : bfba_pkg::TOTAL_W'(total_ext);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        sum_reg       <= sum_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        size_reg      <= size_next;
        n_reg         <= n_next;
        granted_reg   <= granted_next;
        chosen_reg    <= chosen_next;
        total_reg     <= total_next;
    end

    // free size table, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            block_free[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= block_free[rd_addr];
    end

    // result channel
    assign res.valid        = out_valid_reg;
    assign res.granted      = granted_reg;
    assign res.chosen_block = chosen_reg;
    assign res.free_total   = total_reg;

endmodule

`default_nettype wire

// File: bench/best_fit_block_allocator_tb.sv
`timescale 1ns / 100ps

module best_fit_block_allocator_tb;

    localparam int NUM_SLOTS    = 16;
    // longest scan plus a margin, used before register writes and at the end
    localparam int SCAN_SETTLE  = 24;
    localparam int RANDOM_ITEMS = 143;
    localparam int RANDOM_PHASES = 10;
    localparam logic [bfba_pkg::PADDR_W-1:0] BLOCKS_IN_USE_ADDR =
        {bfba_pkg::REG_BLOCKS_IN_USE, 2'b00};

    typedef struct packed {
        logic [bfba_pkg::OP_W-1:0]      op;
        logic [bfba_pkg::SLOT_W-1:0]    slot;
        logic [bfba_pkg::SIZE_IN_W-1:0] size;
    } alloc_item_t;

    typedef struct packed {
        logic                           granted;
        logic [bfba_pkg::SLOT_W-1:0]    chosen_block;
        logic [bfba_pkg::TOTAL_W-1:0]   free_total;
    } alloc_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [bfba_pkg::PADDR_W-1:0]   paddr;
    logic [bfba_pkg::PDATA_W-1:0]   pwdata;
    logic [bfba_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    bfba_req_if req_ch ();
    bfba_res_if res_ch ();

    best_fit_block_allocator #(
        .MAX_BLOCKS (NUM_SLOTS),
        .SIZE_BITS  (bfba_pkg::SIZE_IN_W)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    // shadow copy of the allocator state
    logic [bfba_pkg::SIZE_IN_W-1:0] shadow_free [NUM_SLOTS];
    logic                           shadow_halted = 1'b0;
    logic [bfba_pkg::CFG_W-1:0]     shadow_blocks = bfba_pkg::BLOCKS_IN_USE_RESET;

    alloc_item_t   pending_items[$];
    alloc_result_t expected_grants[$];
    int unsigned   mismatch_count = 0;
    bit            req_fire = 1'b0;

    // clock
    always #5 clk = ~clk;

    // best-fit search on the shadow table; a block write gives no result
    function automatic void best_fit_outcome(input alloc_item_t item,
                                             output bit gives_result,
                                             output alloc_result_t outcome);
        int unsigned                    active;
        int unsigned                    best;
        bit                             found;
        logic [bfba_pkg::SIZE_IN_W-1:0] best_size;
        logic [bfba_pkg::TOTAL_W:0]     sum;
        active       = (shadow_blocks > NUM_SLOTS) ? NUM_SLOTS : shadow_blocks;
        outcome      = '0;
        gives_result = 1'b0;
        if (item.op == bfba_pkg::OP_WRITE)
        begin
            shadow_free[item.slot] = item.size;
            shadow_halted = 1'b0;
            return;
        end
        found     = 1'b0;
        best      = 0;
        best_size = '0;
        if (!shadow_halted)
        begin
            for (int i = 0; i < active; i++)
            begin
                if (shadow_free[i] >= item.size && (!found || shadow_free[i] < best_size))
                begin
                    found     = 1'b1;
                    best      = i;
                    best_size = shadow_free[i];
                end
            end
            if (found)
                shadow_free[best] = shadow_free[best] - item.size;
            else
                shadow_halted = 1'b1;
        end
        sum = '0;
        for (int i = 0; i < active; i++)
            sum += shadow_free[i];
        outcome.granted      = found;
        outcome.chosen_block = found ? bfba_pkg::SLOT_W'(best) : '0;
        outcome.free_total   = (sum > bfba_pkg::TOTAL_MAX) ? bfba_pkg::TOTAL_MAX
                                                           : sum[bfba_pkg::TOTAL_W-1:0];
        gives_result         = 1'b1;
    endfunction

    // accepted transfers on both channels: predict and check
    always @(posedge clk)
    begin : transfer_monitor
        alloc_item_t   item;
        alloc_result_t outcome;
        alloc_result_t want;
        bit            gives_result;
        req_fire = rst_n && req_ch.valid && req_ch.ready;
        if (req_fire)
        begin
            item.op   = req_ch.op;
            item.slot = req_ch.block_slot;
            item.size = req_ch.size_value;
            best_fit_outcome(item, gives_result, outcome);
            if (gives_result)
                expected_grants.insert(expected_grants.size(), outcome);
        end
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_grants.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result granted %0d block %0d total %0d", $time,
                             res_ch.granted, res_ch.chosen_block, res_ch.free_total);
            end
            else
            begin
                want = expected_grants.pop_front();
                if (res_ch.granted !== want.granted || res_ch.chosen_block !== want.chosen_block
                    || res_ch.free_total !== want.free_total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch expected granted %0d block %0d total %0d,",
                                  " got %0d %0d %0d"},
                                 $time, want.granted, want.chosen_block, want.free_total,
                                 res_ch.granted, res_ch.chosen_block, res_ch.free_total);
                end
            end
        end
    end

    // request driver: bursts of transfers with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge clk)
    begin : item_driver
        alloc_item_t next_item;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_fire)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                req_ch.op         <= next_item.op;
                req_ch.block_slot <= next_item.slot;
                req_ch.size_value <= next_item.size;
                req_ch.valid      <= 1'b1;
                if (burst_left != 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result receiver: stalls follow a rotating pattern, renewed now and then
    logic [31:0] stall_pattern = '1;
    int unsigned pattern_left  = 0;

    always @(negedge clk)
    begin : result_receiver
        if (pattern_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       stall_pattern = '1;
                1:       stall_pattern = $urandom;
                2:       stall_pattern = $urandom | $urandom;
                default: stall_pattern = $urandom & $urandom;
            endcase
            pattern_left = 96;
        end
        res_ch.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
        pattern_left--;
    end

    // one register port access, setup then access phase
    task automatic apb_access(input bit is_write, input logic [bfba_pkg::PDATA_W-1:0] wdata,
                              output logic [bfba_pkg::PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= BLOCKS_IN_USE_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write blocks_in_use and read it back
    task automatic set_blocks_in_use(input logic [bfba_pkg::CFG_W-1:0] value);
        logic [bfba_pkg::PDATA_W-1:0] readback;
        apb_access(1'b1, bfba_pkg::PDATA_W'(value), readback);
        shadow_blocks = value;
        apb_access(1'b0, '0, readback);
        if (readback[bfba_pkg::CFG_W-1:0] !== value)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: blocks_in_use readback expected %0d, got %0d", $time,
                         value, readback[bfba_pkg::CFG_W-1:0]);
        end
    endtask

    // wait until every transfer is taken and every result has come back
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || expected_grants.size() != 0 || req_ch.valid);
        repeat (SCAN_SETTLE) @(posedge clk);
    endtask

    task automatic queue_item(input logic [bfba_pkg::OP_W-1:0] op,
                              input logic [bfba_pkg::SLOT_W-1:0] slot,
                              input logic [bfba_pkg::SIZE_IN_W-1:0] size);
        alloc_item_t item;
        item.op   = op;
        item.slot = slot;
        item.size = size;
        pending_items.insert(pending_items.size(), item);
    endtask

    // mostly small requests against full-range block writes
    function automatic alloc_item_t random_item();
        alloc_item_t                    item;
        logic [bfba_pkg::SIZE_IN_W-1:0] mask;
        mask      = bfba_pkg::SIZE_IN_W'((32'd1 << $urandom_range(1, bfba_pkg::SIZE_IN_W)) - 1);
        item.slot = bfba_pkg::SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        if ($urandom_range(0, 99) < 35)
        begin
            item.op = bfba_pkg::OP_WRITE;
            case ($urandom_range(0, 7))
                0:       item.size = '0;
                1:       item.size = '1;
                2, 3:    item.size = bfba_pkg::SIZE_IN_W'($urandom) & mask;
                default: item.size = bfba_pkg::SIZE_IN_W'($urandom);
            endcase
        end
        else
        begin
            item.op = bfba_pkg::OP_REQUEST;
            case ($urandom_range(0, 15))
                0:       item.size = '0;
                1:       item.size = '1;
                default: item.size = bfba_pkg::SIZE_IN_W'($urandom) & mask;
            endcase
        end
        return item;
    endfunction

    // reset, directed cases, then random phases over several table sizes
    initial
    begin : stimulus
        logic [bfba_pkg::SIZE_IN_W-1:0] fill_sizes [NUM_SLOTS];
        logic [bfba_pkg::CFG_W-1:0]     phase_blocks [7];
        logic [bfba_pkg::CFG_W-1:0]     blocks;
        fill_sizes   = '{16'd100, 16'hFFFF, 16'd0, 16'd100, 16'd500, 16'd1000, 16'd2000,
                         16'd3000, 16'd4000, 16'd5000, 16'd6000, 16'd7000, 16'd8000,
                         16'd9000, 16'd10000, 16'd11000};
        phase_blocks = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd17, 5'd16};
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req_ch.valid      = 1'b0;
        req_ch.op         = bfba_pkg::OP_WRITE;
        req_ch.block_slot = '0;
        req_ch.size_value = '0;
        res_ch.ready      = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill every entry, then zero request, tie, largest, no fit, halted, restart
        wait_quiet();
        set_blocks_in_use(5'd16);
        for (int i = 0; i < NUM_SLOTS; i++)
            queue_item(bfba_pkg::OP_WRITE, bfba_pkg::SLOT_W'(i), fill_sizes[i]);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'd0);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'd100);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'hFFFF);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'hFFFF);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'd1);
        queue_item(bfba_pkg::OP_WRITE, 4'd2, 16'd50);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'd1);

        // no blocks in use
        wait_quiet();
        set_blocks_in_use(5'd0);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'd0);
        queue_item(bfba_pkg::OP_WRITE, 4'd15, 16'd7);

        // count above the table size saturates
        wait_quiet();
        set_blocks_in_use(5'd31);
        queue_item(bfba_pkg::OP_REQUEST, '0, 16'd7);

        // random phases
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            blocks = (p < 7) ? phase_blocks[p]
                             : bfba_pkg::CFG_W'($urandom_range(1, NUM_SLOTS));
            wait_quiet();
            set_blocks_in_use(blocks);
            for (int k = 0; k < RANDOM_ITEMS; k++)
                pending_items.insert(pending_items.size(), random_item());
        end

        wait_quiet();
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // run limit
    initial
    begin : run_limit
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: best_fit_block_allocator.f
rtl/bfba_pkg.sv
rtl/bfba_req_if.sv
rtl/bfba_res_if.sv
rtl/bfba_apb_regs.sv
rtl/best_fit_block_allocator.sv
bench/best_fit_block_allocator_tb.sv
